// ===== rtl/core/kic_pkg.sv =====
// Shared types and constants for the keypad integer calculator.
// No dependencies; compiled first.
`default_nettype none
package kic_pkg;

	localparam int DATA_W     = 32;
	localparam int LIMIT_W    = 31;
	localparam int BCD_W      = 40;
	localparam int CNT_W      = 4;
	localparam int DIGITS_DEF = 10;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 31'd99999999;
	localparam logic [DATA_W-1:0]  PCT_DIV   = 32'd100;
	localparam logic [3:0]         DIGIT_MAX = 4'd9;

	typedef enum logic [3:0] {
		ACT_DIGIT   = 4'd0,
		ACT_ADD     = 4'd1,
		ACT_SUB     = 4'd2,
		ACT_MUL     = 4'd3,
		ACT_DIV     = 4'd4,
		ACT_EQUALS  = 4'd5,
		ACT_CLEAR   = 4'd6,
		ACT_NEGATE  = 4'd7,
		ACT_PERCENT = 4'd8
	} action_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CONV_START,
		ST_CONV,
		ST_HOLD
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/kic_if.sv =====
// Handshake channels for key actions and display results.
// Depends on kic_pkg for field widths.
`default_nettype none
interface kic_key_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [3:0] digit_value;

	modport source (output valid, action, digit_value, input ready);
	modport sink (input valid, action, digit_value, output ready);
endinterface

interface kic_show_if
	import kic_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] shown_value;
	logic                     shown_negative;
	logic [BCD_W-1:0]         shown_bcd;
	logic [CNT_W-1:0]         shown_digit_count;

	modport source (output valid, shown_value, shown_negative, shown_bcd, shown_digit_count,
		input ready);
	modport sink (input valid, shown_value, shown_negative, shown_bcd, shown_digit_count,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kic_div.sv =====
// Iterative signed truncating divider, one quotient bit per cycle.
// Depends on kic_pkg.
`default_nettype none
module kic_div
	import kic_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [DATA_W-1:0] divisor,
	output logic                   done,
	output logic [DATA_W-1:0]      quotient
);
	localparam int DIV_CNT_W = $clog2(DATA_W);
	localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DATA_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    mb_q;
	logic                 neg_q;
	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, mb_q};
	assign ge      = shifted >= {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
			mb_q  <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/kic_bcd.sv =====
// Shift-and-add-3 binary to BCD converter, one input bit per cycle,
// plus the significant digit count. Depends on kic_pkg.
`default_nettype none
module kic_bcd
	import kic_pkg::*;
#(
	parameter int DIGITS = DIGITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [DATA_W-1:0]   mag,
	output logic                     done,
	output logic [4*DIGITS-1:0]      bcd,
	output logic [CNT_W-1:0]         count
);
	localparam int BCD_CNT_W = $clog2(DATA_W);
	localparam logic [BCD_CNT_W-1:0] CNT_LAST = BCD_CNT_W'(DATA_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [BCD_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    bin_q;
	logic [4*DIGITS-1:0]  bcd_q;
	logic [4*DIGITS-1:0]  adj;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			// top digit carry is dropped: result is mag mod 10^DIGITS
			bcd_q <= {adj[4*DIGITS-2:0], bin_q[DATA_W-1]};
			bin_q <= {bin_q[DATA_W-2:0], 1'b0};
		end
	end

	always_comb begin
		count = CNT_W'(1);
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				count = CNT_W'(i + 1);
			end
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

// ===== rtl/core/keypad_integer_calculator.sv =====
// Keypad integer calculator top level: key sequencer, registers, result slot.
// Depends on kic_pkg, kic_if, kic_div and kic_bcd.
//
//  channel | dir | handshake         | payload
//  key     | in  | valid/ready       | action, digit_value
//  show    | out | valid/ready       | shown_value, shown_negative, shown_bcd, shown_digit_count
//  cfg     | in  | cfg_we (no ready) | cfg_wdata = entry_limit
//
// A key is held off until the sequencer is idle again after the 32-step BCD converter;
// a pending divide by a nonzero entry, and percent, first pass through the 32-step
// divider. The result is loaded in the cycle before the next key can go.
// key.ready is high only while the sequencer is idle; one result waits in
// the output register while the next key is taken. A stalled show channel
// holds the sequencer once a second result is ready.
// arst_n clears all control state and sets entry_limit to 99999999.
`default_nettype none
module keypad_integer_calculator
	import kic_pkg::*;
#(
	parameter int DECIMAL_DIGITS = DIGITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	kic_key_if.sink                 key,
	kic_show_if.source              show,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata
);
	state_t               state_q, state_d;
	logic [LIMIT_W-1:0]   limit_q;
	logic [DATA_W-1:0]    acc_q;
	logic [DATA_W-1:0]    entry_q;
	op_t                  pending_q;
	logic                 fresh_q;
	logic                 div_to_acc_q;

	logic                 out_valid_q;
	logic [DATA_W-1:0]    out_value_q;
	logic                 out_neg_q;
	logic [BCD_W-1:0]     out_bcd_q;
	logic [CNT_W-1:0]     out_cnt_q;

	action_t              act;
	logic                 key_xfer;
	logic                 is_apply;
	logic                 div_start;
	logic [DATA_W-1:0]    div_a;
	logic [DATA_W-1:0]    div_b;
	logic                 div_done;
	logic [DATA_W-1:0]    div_q;
	logic                 bcd_start;
	logic                 bcd_done;
	logic [4*DECIMAL_DIGITS-1:0] bcd_res;
	logic [CNT_W-1:0]     bcd_cnt;
	logic [DATA_W-1:0]    mag;
	logic                 slot_free;
	logic                 out_load;
	logic                 key_ready;

	logic signed [DATA_W+3:0] base_x;
	logic signed [DATA_W+3:0] digit_x;
	logic [DATA_W-1:0]        digit_res;
	logic [DATA_W-1:0]        mul_res;
	logic [DATA_W-1:0]        apply_res;

	assign act      = action_t'(key.action);
	assign key_xfer = key.valid && key_ready;
	assign is_apply = (act == ACT_ADD) || (act == ACT_SUB) || (act == ACT_MUL)
		|| (act == ACT_DIV) || (act == ACT_EQUALS);
	assign div_start = key_xfer && ((is_apply && (pending_q == OP_DIV) && (entry_q != '0))
		|| (act == ACT_PERCENT));
	assign div_a = (act == ACT_PERCENT) ? entry_q : acc_q;
	assign div_b = (act == ACT_PERCENT) ? PCT_DIV : entry_q;

	// digit entry: exact base*10+d, then clamp
	assign base_x  = fresh_q ? '0 : $signed({{4{entry_q[DATA_W-1]}}, entry_q});
	assign digit_x = (base_x <<< 3) + (base_x <<< 1)
		+ $signed({{DATA_W{1'b0}}, key.digit_value});

	always_comb begin
		if (digit_x > $signed({5'b0, limit_q})) begin
			digit_res = DATA_W'(limit_q);
		end else if (digit_x < $signed({4'hF, 1'b1, {(DATA_W-1){1'b0}}})) begin
			digit_res = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			digit_res = digit_x[DATA_W-1:0];
		end
	end

	assign mul_res = acc_q * entry_q;

	always_comb begin
		unique case (pending_q)
			OP_ADD:  apply_res = acc_q + entry_q;
			OP_SUB:  apply_res = acc_q - entry_q;
			OP_MUL:  apply_res = mul_res;
			OP_DIV:  apply_res = acc_q;
			default: apply_res = entry_q;
		endcase
	end

	assign mag = entry_q[DATA_W-1] ? (DATA_W'(0) - entry_q) : entry_q;

	kic_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	kic_bcd #(
		.DIGITS (DECIMAL_DIGITS)
	) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.mag    (mag),
		.done   (bcd_done),
		.bcd    (bcd_res),
		.count  (bcd_cnt)
	);

	assign slot_free = !out_valid_q || show.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (key_xfer) begin
					state_d = div_start ? ST_DIV : ST_CONV_START;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_CONV_START;
				end
			end
			ST_CONV_START: state_d = ST_CONV;
			ST_CONV: begin
				if (bcd_done) begin
					state_d = slot_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		key_ready = (state_q == ST_IDLE);
		bcd_start = (state_q == ST_CONV_START);
		out_load  = ((state_q == ST_CONV) && bcd_done && slot_free)
			|| ((state_q == ST_HOLD) && slot_free);
	end

	assign key.ready = key_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			limit_q      <= LIMIT_RST;
			acc_q        <= '0;
			entry_q      <= '0;
			pending_q    <= OP_NONE;
			fresh_q      <= 1'b1;
			div_to_acc_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (key_xfer) begin
				unique case (act)
					ACT_DIGIT: begin
						if (key.digit_value <= DIGIT_MAX) begin
							entry_q <= digit_res;
							fresh_q <= 1'b0;
						end
					end
					ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_EQUALS: begin
						if (!div_start) begin
							acc_q   <= apply_res;
							entry_q <= apply_res;
						end
						div_to_acc_q <= 1'b1;
						pending_q    <= (act == ACT_EQUALS) ? OP_NONE : op_t'(key.action[2:0]);
						fresh_q      <= 1'b1;
					end
					ACT_CLEAR: begin
						acc_q     <= '0;
						entry_q   <= '0;
						pending_q <= OP_NONE;
						fresh_q   <= 1'b1;
					end
					ACT_NEGATE: entry_q <= DATA_W'(0) - entry_q;
					ACT_PERCENT: div_to_acc_q <= 1'b0;
					default: ;
				endcase
			end
			if ((state_q == ST_DIV) && div_done) begin
				entry_q <= div_q;
				if (div_to_acc_q) begin
					acc_q <= div_q;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (show.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= entry_q;
			out_neg_q   <= entry_q[DATA_W-1];
			out_bcd_q   <= BCD_W'(bcd_res);
			out_cnt_q   <= bcd_cnt;
		end
	end

	assign show.valid             = out_valid_q;
	assign show.shown_value       = $signed(out_value_q);
	assign show.shown_negative    = out_neg_q;
	assign show.shown_bcd         = out_bcd_q;
	assign show.shown_digit_count = out_cnt_q;

endmodule
`default_nettype wire
